### hw/rtl/mau_pkg.sv
`timescale 1ns / 1ps
// mau_pkg: widths, codes and controller/datapath interface types
// for the modular arithmetic unit; no dependencies

package mau_pkg;

    localparam int MOD_W  = 31;
    localparam int EXP_W  = 63;
    localparam int ACT_W  = 3;
    localparam int CNT_W  = 5;
    localparam int DIN_W  = 128;
    localparam int DOUT_W = 32;

    localparam logic [MOD_W-1:0] MOD_RESET = 31'd1000000007;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD = 3'd0,
        ACT_SUB = 3'd1,
        ACT_MUL = 3'd2,
        ACT_DIV = 3'd3,
        ACT_POW = 3'd4,
        ACT_NEG = 3'd5,
        ACT_INV = 3'd6
    } act_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ADD,
        OP_SUB,
        OP_NEG,
        OP_ZERO,
        OP_ERR,
        OP_COPY_U,
        OP_POW_INIT
    } op_t;

    typedef enum logic [2:0] {
        SEL_RED_A,
        SEL_RED_B,
        SEL_AB,
        SEL_UT,
        SEL_TT,
        SEL_AU
    } sel_t;

    typedef enum logic [2:0] {
        DST_A,
        DST_B,
        DST_U,
        DST_T,
        DST_R
    } dest_t;

    typedef struct packed {
        logic  mul_start;
        sel_t  mul_sel;
        logic  wb;
        dest_t wb_dest;
        op_t   op;
        logic  pow_base_b;
        logic  pow_exp_inv;
        logic  emit;
    } cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             a_zero;
        logic             b_zero;
        logic             e_zero;
        logic             e_lsb;
        logic             mul_busy;
        logic             mul_done;
        logic             out_valid;
    } status_t;

endpackage

### hw/rtl/mau_modmul.sv
`timescale 1ns / 1ps
// mau_modmul: bit-serial interleaved modular multiplier, one multiplier bit
// per cycle from the top; uses mau_pkg

module mau_modmul (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [mau_pkg::MOD_W-1:0] x,
    input  logic [mau_pkg::MOD_W-1:0] y,
    input  logic [mau_pkg::MOD_W-1:0] m,
    output logic                      busy,
    output logic                      done,
    output logic [mau_pkg::MOD_W-1:0] prod
);

    logic [mau_pkg::MOD_W-1:0] acc_reg, acc_next;
    logic [mau_pkg::MOD_W-1:0] x_reg;
    logic [mau_pkg::MOD_W-1:0] y_reg;
    logic [mau_pkg::CNT_W-1:0] cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic [mau_pkg::MOD_W+1:0] sum;
    logic [mau_pkg::MOD_W+1:0] m1;
    logic [mau_pkg::MOD_W+1:0] m2;

    // acc < m and x < m, so the sum stays below 3m
    always_comb begin
        m1  = {2'b00, m};
        m2  = {1'b0, m, 1'b0};
        sum = {1'b0, acc_reg, 1'b0}
            + (y_reg[mau_pkg::MOD_W-1] ? {2'b00, x_reg} : '0);
        if (sum >= m2) begin
            acc_next = mau_pkg::MOD_W'(sum - m2);
        end else if (sum >= m1) begin
            acc_next = mau_pkg::MOD_W'(sum - m1);
        end else begin
            acc_next = mau_pkg::MOD_W'(sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                acc_reg  <= '0;
                x_reg    <= x;
                y_reg    <= y;
            end else if (busy_reg) begin
                acc_reg <= acc_next;
                y_reg   <= {y_reg[mau_pkg::MOD_W-2:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == mau_pkg::CNT_W'(mau_pkg::MOD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign prod = acc_reg;

endmodule

### hw/rtl/mau_datapath.sv
`timescale 1ns / 1ps
// mau_datapath: modulus register, operand and power registers, add/sub/negate
// logic, output register; uses mau_pkg and mau_modmul

module mau_datapath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [mau_pkg::MOD_W-1:0]  cfg_wr_data,
    input  logic                       in_accept,
    input  logic [mau_pkg::ACT_W-1:0]  in_act,
    input  logic [mau_pkg::MOD_W-1:0]  in_a,
    input  logic [mau_pkg::MOD_W-1:0]  in_b,
    input  logic [mau_pkg::EXP_W-1:0]  in_e,
    input  logic                       out_ready,
    input  mau_pkg::cmd_t              cmd,
    output mau_pkg::status_t           status,
    output logic [mau_pkg::MOD_W-1:0]  out_result,
    output logic                       out_err
);

    logic [mau_pkg::MOD_W-1:0] mod_reg;
    logic [mau_pkg::ACT_W-1:0] act_reg;
    logic [mau_pkg::MOD_W-1:0] a_raw_reg, b_raw_reg;
    logic [mau_pkg::MOD_W-1:0] a_reg, b_reg, u_reg, t_reg, r_reg;
    logic [mau_pkg::EXP_W-1:0] e_raw_reg, e_reg;
    logic                      err_reg;
    logic [mau_pkg::MOD_W-1:0] out_result_reg;
    logic                      out_err_reg;
    logic                      out_valid_reg;

    logic [mau_pkg::MOD_W-1:0] m_eff;
    logic [mau_pkg::MOD_W-1:0] one;
    logic [mau_pkg::MOD_W-1:0] mx, my;
    logic [mau_pkg::MOD_W-1:0] prod;
    logic                      mul_busy, mul_done;
    logic [mau_pkg::MOD_W:0]   add_sum;
    logic [mau_pkg::MOD_W:0]   sub_dif;
    logic [mau_pkg::MOD_W-1:0] add_res, sub_res, neg_res;
    logic [mau_pkg::EXP_W-1:0] inv_exp;

    always_comb begin
        m_eff = (mod_reg == '0) ? mau_pkg::MOD_W'(1) : mod_reg;
        one   = (m_eff == mau_pkg::MOD_W'(1)) ? '0 : mau_pkg::MOD_W'(1);

        add_sum = {1'b0, a_reg} + {1'b0, b_reg};
        add_res = (add_sum >= {1'b0, m_eff}) ? mau_pkg::MOD_W'(add_sum - {1'b0, m_eff})
                                              : mau_pkg::MOD_W'(add_sum);
        sub_dif = {1'b0, a_reg} - {1'b0, b_reg}
                + ((a_reg < b_reg) ? {1'b0, m_eff} : '0);
        sub_res = mau_pkg::MOD_W'(sub_dif);
        neg_res = (a_reg == '0) ? '0 : m_eff - a_reg;
        inv_exp = (m_eff >= mau_pkg::MOD_W'(2))
                ? mau_pkg::EXP_W'(m_eff - mau_pkg::MOD_W'(2)) : '0;

        case (cmd.mul_sel)
            mau_pkg::SEL_RED_A: begin
                mx = one;
                my = a_raw_reg;
            end
            mau_pkg::SEL_RED_B: begin
                mx = one;
                my = b_raw_reg;
            end
            mau_pkg::SEL_AB: begin
                mx = a_reg;
                my = b_reg;
            end
            mau_pkg::SEL_UT: begin
                mx = u_reg;
                my = t_reg;
            end
            mau_pkg::SEL_TT: begin
                mx = t_reg;
                my = t_reg;
            end
            mau_pkg::SEL_AU: begin
                mx = a_reg;
                my = u_reg;
            end
            default: begin
                mx = '0;
                my = '0;
            end
        endcase
    end

    mau_modmul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .x       (mx),
        .y       (my),
        .m       (m_eff),
        .busy    (mul_busy),
        .done    (mul_done),
        .prod    (prod)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_reg       <= mau_pkg::MOD_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                mod_reg <= cfg_wr_data;
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end

        if (in_accept) begin
            act_reg   <= in_act;
            a_raw_reg <= in_a;
            b_raw_reg <= in_b;
            e_raw_reg <= in_e;
        end

        if (cmd.emit) begin
            out_result_reg <= r_reg;
            out_err_reg    <= err_reg;
        end

        if (cmd.wb) begin
            case (cmd.wb_dest)
                mau_pkg::DST_A: a_reg <= prod;
                mau_pkg::DST_B: b_reg <= prod;
                mau_pkg::DST_U: u_reg <= prod;
                mau_pkg::DST_T: begin
                    t_reg <= prod;
                    e_reg <= e_reg >> 1;
                end
                mau_pkg::DST_R: begin
                    r_reg   <= prod;
                    err_reg <= 1'b0;
                end
                default: ;
            endcase
        end

        case (cmd.op)
            mau_pkg::OP_ADD: begin
                r_reg   <= add_res;
                err_reg <= 1'b0;
            end
            mau_pkg::OP_SUB: begin
                r_reg   <= sub_res;
                err_reg <= 1'b0;
            end
            mau_pkg::OP_NEG: begin
                r_reg   <= neg_res;
                err_reg <= 1'b0;
            end
            mau_pkg::OP_ZERO: begin
                r_reg   <= '0;
                err_reg <= 1'b0;
            end
            mau_pkg::OP_ERR: begin
                r_reg   <= '0;
                err_reg <= 1'b1;
            end
            mau_pkg::OP_COPY_U: begin
                r_reg   <= u_reg;
                err_reg <= 1'b0;
            end
            mau_pkg::OP_POW_INIT: begin
                t_reg <= cmd.pow_base_b ? b_reg : a_reg;
                u_reg <= one;
                e_reg <= cmd.pow_exp_inv ? inv_exp : e_raw_reg;
            end
            default: ;
        endcase
    end

    always_comb begin
        status.act       = act_reg;
        status.a_zero    = (a_reg == '0);
        status.b_zero    = (b_reg == '0);
        status.e_zero    = (e_reg == '0);
        status.e_lsb     = e_reg[0];
        status.mul_busy  = mul_busy;
        status.mul_done  = mul_done;
        status.out_valid = out_valid_reg;
    end

    assign out_result = out_result_reg;
    assign out_err    = out_err_reg;

endmodule

### hw/rtl/mau_ctrl.sv
`timescale 1ns / 1ps
// mau_ctrl: sequencer for operand reduction, action dispatch and the
// square-and-multiply loop; uses mau_pkg

module mau_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  logic             out_ready,
    input  mau_pkg::status_t status,
    output logic             in_ready,
    output mau_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RED_A,
        S_RED_B,
        S_DISPATCH,
        S_POW_TOP,
        S_POW_SQ,
        S_WAIT,
        S_GAP,
        S_FINISH
    } state_t;

    typedef enum logic [2:0] {
        K_RA,
        K_RB,
        K_AB,
        K_UT,
        K_TT,
        K_AU,
        K_INIT
    } kind_t;

    state_t        state_reg, state_next;
    kind_t         kind_reg, kind_next;
    logic          ready_reg, ready_next;
    mau_pkg::cmd_t cmd_reg, cmd_next;
    mau_pkg::act_t act;

    assign act = mau_pkg::act_t'(status.act);

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        ready_next = ready_reg;
        cmd_next   = '0;

        case (state_reg)
            S_IDLE: begin
                if (in_valid && ready_reg) begin
                    ready_next = 1'b0;
                    state_next = S_RED_A;
                end
            end
            S_RED_A: begin
                cmd_next.mul_start = 1'b1;
                cmd_next.mul_sel   = mau_pkg::SEL_RED_A;
                kind_next          = K_RA;
                state_next         = S_WAIT;
            end
            S_RED_B: begin
                cmd_next.mul_start = 1'b1;
                cmd_next.mul_sel   = mau_pkg::SEL_RED_B;
                kind_next          = K_RB;
                state_next         = S_WAIT;
            end
            S_DISPATCH: begin
                state_next = S_FINISH;
                case (act)
                    mau_pkg::ACT_ADD: cmd_next.op = mau_pkg::OP_ADD;
                    mau_pkg::ACT_SUB: cmd_next.op = mau_pkg::OP_SUB;
                    mau_pkg::ACT_NEG: cmd_next.op = mau_pkg::OP_NEG;
                    mau_pkg::ACT_MUL: begin
                        cmd_next.mul_start = 1'b1;
                        cmd_next.mul_sel   = mau_pkg::SEL_AB;
                        kind_next          = K_AB;
                        state_next         = S_WAIT;
                    end
                    mau_pkg::ACT_POW: begin
                        cmd_next.op = mau_pkg::OP_POW_INIT;
                        kind_next   = K_INIT;
                        state_next  = S_GAP;
                    end
                    mau_pkg::ACT_INV: begin
                        if (status.a_zero) begin
                            cmd_next.op = mau_pkg::OP_ERR;
                        end else begin
                            cmd_next.op          = mau_pkg::OP_POW_INIT;
                            cmd_next.pow_exp_inv = 1'b1;
                            kind_next            = K_INIT;
                            state_next           = S_GAP;
                        end
                    end
                    mau_pkg::ACT_DIV: begin
                        if (status.b_zero) begin
                            cmd_next.op = mau_pkg::OP_ERR;
                        end else begin
                            cmd_next.op          = mau_pkg::OP_POW_INIT;
                            cmd_next.pow_base_b  = 1'b1;
                            cmd_next.pow_exp_inv = 1'b1;
                            kind_next            = K_INIT;
                            state_next           = S_GAP;
                        end
                    end
                    default: cmd_next.op = mau_pkg::OP_ZERO;
                endcase
            end
            S_POW_TOP: begin
                if (status.e_zero) begin
                    if (act == mau_pkg::ACT_DIV) begin
                        cmd_next.mul_start = 1'b1;
                        cmd_next.mul_sel   = mau_pkg::SEL_AU;
                        kind_next          = K_AU;
                        state_next         = S_WAIT;
                    end else begin
                        cmd_next.op = mau_pkg::OP_COPY_U;
                        state_next  = S_FINISH;
                    end
                end else if (status.e_lsb) begin
                    cmd_next.mul_start = 1'b1;
                    cmd_next.mul_sel   = mau_pkg::SEL_UT;
                    kind_next          = K_UT;
                    state_next         = S_WAIT;
                end else begin
                    state_next = S_POW_SQ;
                end
            end
            S_POW_SQ: begin
                cmd_next.mul_start = 1'b1;
                cmd_next.mul_sel   = mau_pkg::SEL_TT;
                kind_next          = K_TT;
                state_next         = S_WAIT;
            end
            S_WAIT: begin
                if (status.mul_done) begin
                    cmd_next.wb = 1'b1;
                    case (kind_reg)
                        K_RA:    cmd_next.wb_dest = mau_pkg::DST_A;
                        K_RB:    cmd_next.wb_dest = mau_pkg::DST_B;
                        K_UT:    cmd_next.wb_dest = mau_pkg::DST_U;
                        K_TT:    cmd_next.wb_dest = mau_pkg::DST_T;
                        default: cmd_next.wb_dest = mau_pkg::DST_R;
                    endcase
                    state_next = S_GAP;
                end
            end
            // lets the last write-back land before its flags are looked at
            S_GAP: begin
                case (kind_reg)
                    K_RA: begin
                        if (act inside {mau_pkg::ACT_ADD, mau_pkg::ACT_SUB,
                                        mau_pkg::ACT_MUL, mau_pkg::ACT_DIV}) begin
                            state_next = S_RED_B;
                        end else begin
                            state_next = S_DISPATCH;
                        end
                    end
                    K_RB:         state_next = S_DISPATCH;
                    K_UT:         state_next = S_POW_SQ;
                    K_TT, K_INIT: state_next = S_POW_TOP;
                    default:      state_next = S_FINISH;
                endcase
            end
            S_FINISH: begin
                if (!status.out_valid || out_ready) begin
                    cmd_next.emit = 1'b1;
                    ready_next    = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            kind_reg  <= K_RA;
            ready_reg <= 1'b1;
            cmd_reg   <= '0;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            ready_reg <= ready_next;
            cmd_reg   <= cmd_next;
        end
    end

    assign in_ready = ready_reg;
    assign cmd      = cmd_reg;

endmodule

### hw/rtl/modular_arithmetic_unit.sv
`timescale 1ns / 1ps
// modular_arithmetic_unit: top level joining controller and datapath
// uses mau_pkg, mau_ctrl, mau_datapath (with mau_modmul)
//
// channel   dir  width         contents
// s_*       in   128 + 3 user  operands and exponent in, action in tuser
// m_*       out  32 + 1 user   reduced residue out, zero-inverse flag in tuser
// cfg_*     in   31            modulus write
//
// one item at a time; each modular multiplication runs 31 steps on the shared
// bit-serial multiplier, plus issue and write-back
// add and subtract need two operand reductions, negate one
// power takes up to two multiplications per exponent bit; inverse and divide
// raise to the power m-2, and divide adds one more multiplication
// reset loads the modulus 1000000007; no clearing pass
// a result waiting on m_tready holds only the last step; a new beat is taken meanwhile

module modular_arithmetic_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [mau_pkg::MOD_W-1:0]  cfg_wr_data,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [mau_pkg::DIN_W-1:0]  s_tdata,  // operand_a, operand_b, exponent, zero pad
    input  logic [mau_pkg::ACT_W-1:0]  s_tuser,  // action
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [mau_pkg::DOUT_W-1:0] m_tdata,  // result, zero pad
    output logic                       m_tuser   // zero_inverse_error
);

    mau_pkg::cmd_t             cmd;
    mau_pkg::status_t          status;
    logic                      in_accept;
    logic [mau_pkg::MOD_W-1:0] out_result;

    assign in_accept = s_tvalid && s_tready;

    mau_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .in_ready  (s_tready),
        .cmd       (cmd)
    );

    mau_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_accept   (in_accept),
        .in_act      (s_tuser),
        .in_a        (s_tdata[mau_pkg::MOD_W-1:0]),
        .in_b        (s_tdata[2*mau_pkg::MOD_W-1:mau_pkg::MOD_W]),
        .in_e        (s_tdata[2*mau_pkg::MOD_W+mau_pkg::EXP_W-1:2*mau_pkg::MOD_W]),
        .out_ready   (m_tready),
        .cmd         (cmd),
        .status      (status),
        .out_result  (out_result),
        .out_err     (m_tuser)
    );

    assign m_tvalid = status.out_valid;
    assign m_tdata  = {{(mau_pkg::DOUT_W - mau_pkg::MOD_W){1'b0}}, out_result};

    a_emit_into_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !status.out_valid)
        else $error("result written over a pending output beat");

    a_start_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul_start |-> !status.mul_busy)
        else $error("multiplier restarted while busy");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> !s_tready)
        else $error("second beat taken while an item is in work");

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.mul_start, cmd.wb, cmd.op != mau_pkg::OP_NONE, cmd.emit}))
        else $error("controller issued two commands at once");

endmodule

### test/tb_modular_arithmetic_unit.sv
`timescale 1ns / 1ps
// tb_modular_arithmetic_unit: self-checking bench for the modular arithmetic unit,
// directed and random beats over several moduli, predicted in the bench itself
// depends on mau_pkg and modular_arithmetic_unit

module tb_modular_arithmetic_unit;

    import mau_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNKNOWN = 3'd7;
    localparam logic [MOD_W-1:0] OPERAND_MAX = 31'd2147483646;
    localparam logic [MOD_W-1:0] MODULUS_MAX = 31'h7FFF_FFFF;
    localparam int               LONG_HOLD   = 5000;
    localparam int               PHASES      = 11;
    localparam int               PHASE_BEATS = 114;

    typedef struct {
        logic [ACT_W-1:0] act;
        logic [MOD_W-1:0] opa;
        logic [MOD_W-1:0] opb;
        logic [EXP_W-1:0] expo;
    } operand_item_t;

    typedef struct {
        logic [MOD_W-1:0] residue;
        logic             zero_inv;
    } answer_t;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [MOD_W-1:0]   cfg_wr_data = '0;
    logic               s_tvalid    = 1'b0;
    logic               s_tready;
    logic [DIN_W-1:0]   s_tdata     = '0;  // operand_a, operand_b, exponent, zero pad
    logic [ACT_W-1:0]   s_tuser     = '0;  // action
    logic               m_tvalid;
    logic               m_tready    = 1'b0;
    logic [DOUT_W-1:0]  m_tdata;           // result, zero pad
    logic               m_tuser;           // zero_inverse_error

    operand_item_t pending_items [$];
    answer_t       expected_answers [$];
    operand_item_t cur_item;
    logic [MOD_W-1:0] modulus_shadow = MOD_RESET;
    int            mismatch_count = 0;
    logic [1:0]    tx_wait  = '0;
    logic          tx_burst = 1'b0;
    logic [15:0]   rx_wait  = '0;
    logic          rx_burst = 1'b0;
    logic          hold_req  = 1'b0;
    logic          hold_done = 1'b0;

    modular_arithmetic_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #250_000_000;
        $display("Verification failed");
        $finish;
    end

    // square-and-multiply from the lowest exponent bit
    function automatic longint unsigned mod_power(input longint unsigned base,
                                                  input longint unsigned e,
                                                  input longint unsigned m);
        longint unsigned t;
        longint unsigned u;
        t = base % m;
        u = 1 % m;
        while (e != 0) begin
            if (e[0])
                u = (u * t) % m;
            t = (t * t) % m;
            e = e >> 1;
        end
        return u;
    endfunction

    function automatic longint unsigned fermat_inverse(input longint unsigned a,
                                                       input longint unsigned m);
        return mod_power(a, (m >= 2) ? m - 2 : 0, m);
    endfunction

    function automatic answer_t compute_answer(input operand_item_t it,
                                               input logic [MOD_W-1:0] modv);
        answer_t         ans;
        longint unsigned m;
        longint unsigned a;
        longint unsigned b;
        longint unsigned r;
        m = (modv == 0) ? 1 : modv;
        a = it.opa % m;
        b = it.opb % m;
        r = 0;
        ans.zero_inv = 1'b0;
        case (it.act)
            ACT_ADD: begin
                r = a + b;
                if (r >= m)
                    r = r - m;
            end
            ACT_SUB: r = (a < b) ? a + m - b : a - b;
            ACT_MUL: r = (a * b) % m;
            ACT_DIV: begin
                if (b == 0)
                    ans.zero_inv = 1'b1;
                else
                    r = (a * fermat_inverse(b, m)) % m;
            end
            ACT_POW: r = mod_power(a, it.expo, m);
            ACT_NEG: r = (a == 0) ? 0 : m - a;
            ACT_INV: begin
                if (a == 0)
                    ans.zero_inv = 1'b1;
                else
                    r = fermat_inverse(a, m);
            end
            default: r = 0;
        endcase
        ans.residue = r[MOD_W-1:0];
        return ans;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    endtask

    task automatic queue_item(input logic [ACT_W-1:0] act, input logic [MOD_W-1:0] a,
                              input logic [MOD_W-1:0] b, input logic [EXP_W-1:0] e);
        operand_item_t it;
        it.act  = act;
        it.opa  = a;
        it.opb  = b;
        it.expo = e;
        pending_items.push_back(it);
    endtask

    // edge values around the modulus now and then, else anything in range
    function automatic logic [MOD_W-1:0] draw_operand();
        longint unsigned m;
        longint unsigned v;
        m = modulus_shadow;
        if ($urandom_range(0, 9) >= 2)
            return MOD_W'($urandom_range(0, OPERAND_MAX));
        case ($urandom_range(0, 5))
            0:       v = 0;
            1:       v = 1;
            2:       v = (m == 0) ? 0 : m - 1;
            3:       v = m;
            4:       v = m + 1;
            default: v = OPERAND_MAX;
        endcase
        if (v > OPERAND_MAX)
            v = OPERAND_MAX;
        return v[MOD_W-1:0];
    endfunction

    // mostly short exponents for power, a few full width
    function automatic logic [EXP_W-1:0] draw_exponent(input logic is_pow);
        logic [63:0] raw;
        int          pick;
        int          bits;
        raw  = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (!is_pow || pick >= 95)
            return raw[EXP_W-1:0];
        bits = (pick < 85) ? $urandom_range(0, 16) : $urandom_range(17, 40);
        return raw[EXP_W-1:0] & ((63'd1 << bits) - 63'd1);
    endfunction

    task automatic queue_random_item();
        logic [ACT_W-1:0] act;
        int               pick;
        pick = $urandom_range(0, 99);
        if (pick < 14)      act = ACT_ADD;
        else if (pick < 28) act = ACT_SUB;
        else if (pick < 44) act = ACT_MUL;
        else if (pick < 52) act = ACT_DIV;
        else if (pick < 74) act = ACT_POW;
        else if (pick < 87) act = ACT_NEG;
        else if (pick < 98) act = ACT_INV;
        else                act = ACT_UNKNOWN;
        queue_item(act, draw_operand(), draw_operand(), draw_exponent(act == ACT_POW));
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_tvalid || expected_answers.size() != 0)
            @(posedge aclk);
    endtask

    always @(posedge aclk) begin : drive_beats
        operand_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_wait  <= '0;
        end else begin
            if (s_tvalid && s_tready)
                expected_answers.push_back(compute_answer(cur_item, modulus_shadow));
            if (!s_tvalid || s_tready) begin
                if (tx_wait != 0) begin
                    tx_wait  <= tx_wait - 2'd1;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    nxt = pending_items.pop_front();
                    cur_item <= nxt;
                    s_tdata  <= {3'b000, nxt.expo, nxt.opb, nxt.opa};
                    s_tuser  <= nxt.act;
                    s_tvalid <= 1'b1;
                    tx_wait  <= tx_burst ? 2'd0 : 2'($urandom_range(0, 3));
                    if ($urandom_range(0, 49) == 0)
                        tx_burst <= !tx_burst;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : watch_results
        answer_t want;
        int      n;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait  <= '0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_answers.size() == 0) begin
                    report_mismatch("unexpected beat", m_tdata, 0);
                end else begin
                    want = expected_answers.pop_front();
                    if (m_tdata[MOD_W-1:0] !== want.residue)
                        report_mismatch("result", m_tdata[MOD_W-1:0], want.residue);
                    if (m_tuser !== want.zero_inv)
                        report_mismatch("zero_inverse_error", m_tuser, want.zero_inv);
                end
                if ($urandom_range(0, 39) == 0)
                    rx_burst <= !rx_burst;
            end
            if (hold_req && !hold_done) begin
                hold_done <= 1'b1;
                m_tready  <= 1'b0;
                rx_wait   <= 16'(LONG_HOLD);
            end else if (m_tvalid && m_tready) begin
                n = rx_burst ? 0 : $urandom_range(0, 3);
                m_tready <= (n == 0);
                rx_wait  <= 16'(n);
            end else if (rx_wait != 0) begin
                rx_wait  <= rx_wait - 16'd1;
                m_tready <= (rx_wait == 16'd1);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic [MOD_W-1:0] mods [PHASES];
        longint unsigned  dm;
        mods = '{MODULUS_MAX, 31'd2, 31'd0, 31'd1, 31'd15, 31'd65521, MOD_RESET,
                 31'd0, 31'd0, 31'd0, 31'd0};
        mods[7]  = MOD_W'($urandom_range(3, 1000));
        mods[8]  = MOD_W'($urandom_range(3, MODULUS_MAX));
        mods[9]  = MOD_W'($urandom_range(3, MODULUS_MAX));
        mods[10] = MOD_W'($urandom_range(1 << 30, MODULUS_MAX));
        dm = MOD_RESET;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset modulus: field extremes, every action, zero inverse, zero power
        queue_item(ACT_ADD, OPERAND_MAX, OPERAND_MAX, '0);
        queue_item(ACT_ADD, 31'(dm - 1), 31'd1, '1);
        queue_item(ACT_SUB, 31'd0, 31'd1, '0);
        queue_item(ACT_SUB, 31'd12345, 31'(dm + 12345), '0);
        queue_item(ACT_MUL, 31'(dm - 1), 31'(dm - 1), '0);
        queue_item(ACT_MUL, OPERAND_MAX, OPERAND_MAX, 63'h5555_5555_5555_5555);
        queue_item(ACT_DIV, 31'd5, 31'd0, '0);
        queue_item(ACT_DIV, 31'd5, 31'(dm), '0);
        queue_item(ACT_DIV, 31'd7, 31'd3, '0);
        queue_item(ACT_DIV, 31'd0, 31'd5, '0);
        queue_item(ACT_POW, 31'd0, 31'd9, '0);
        queue_item(ACT_POW, 31'(dm), OPERAND_MAX, '0);
        queue_item(ACT_POW, 31'd0, 31'd0, 63'd5);
        queue_item(ACT_POW, 31'd3, 31'd0, '1);
        queue_item(ACT_POW, OPERAND_MAX, 31'd0, 63'd1);
        queue_item(ACT_POW, 31'd2, 31'd0, 63'h2AAA_AAAA_AAAA_AAAA);
        queue_item(ACT_NEG, 31'd0, OPERAND_MAX, '1);
        queue_item(ACT_NEG, 31'd1, 31'd0, '0);
        queue_item(ACT_NEG, OPERAND_MAX, 31'd0, '0);
        queue_item(ACT_INV, 31'd0, 31'd1, '0);
        queue_item(ACT_INV, 31'(dm), 31'd1, '0);
        queue_item(ACT_INV, 31'd2, OPERAND_MAX, '1);
        queue_item(ACT_INV, 31'(dm - 1), 31'd0, '0);
        queue_item(ACT_UNKNOWN, 31'd77, 31'd88, 63'd99);

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            cfg_wr_en      <= 1'b1;
            cfg_wr_data    <= mods[p];
            modulus_shadow  = mods[p];
            @(posedge aclk);
            cfg_wr_en <= 1'b0;
            @(posedge aclk);
            repeat (PHASE_BEATS) queue_random_item();
            // stall the result side long enough for the input to back up
            if (p == 1)
                hold_req = 1'b1;
        end

        wait_drained();
        repeat (5000) @(posedge aclk);
        if (expected_answers.size() != 0)
            report_mismatch("results missing at end", 0, expected_answers.size());
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### files.f
hw/rtl/mau_pkg.sv
hw/rtl/mau_modmul.sv
hw/rtl/mau_datapath.sv
hw/rtl/mau_ctrl.sv
hw/rtl/modular_arithmetic_unit.sv
test/tb_modular_arithmetic_unit.sv
